FILE: src/rrta_pkg.sv
`default_nettype none

package rrta_pkg;

  // Number of requester slots and the widths that follow from it.
  localparam int MaxSlots = 8;
  localparam int SlotW    = 3;
  localparam int CntW     = 4;

  // Command codes.
  localparam logic [2:0] CmdConnect    = 3'd0;
  localparam logic [2:0] CmdDisconnect = 3'd1;
  localparam logic [2:0] CmdAdvance    = 3'd2;
  localparam logic [2:0] CmdTick       = 3'd3;
  localparam logic [2:0] CmdStart      = 3'd4;
  localparam logic [2:0] CmdEnd        = 3'd5;

  // Status codes.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StNone  = 2'd2;

  // Answers of the shared step unit for one cycle of the search.
  typedef struct packed {
    logic            hit;
    logic            last;
    logic            ge;
    logic [CntW-1:0] reduced;
    logic [CntW-1:0] stepped;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: src/rrta_scan_unit.sv
`default_nettype none

// One step of the slot search: tests the slot under the cursor, steps the
// cursor with wrap at the active count, and reduces a start index that is
// not yet below the count by one subtraction.
module rrta_scan_unit (
  input  wire logic [rrta_pkg::CntW-1:0]   idx_i,
  input  wire logic [rrta_pkg::CntW-1:0]   step_i,
  input  wire logic [rrta_pkg::CntW-1:0]   n_i,
  input  wire logic [rrta_pkg::MaxSlots-1:0] mask_i,
  output rrta_pkg::scan_res_t              res_o
);

  logic [rrta_pkg::CntW-1:0] inc;

  assign inc = idx_i + rrta_pkg::CntW'(1);

  always_comb begin
    res_o.hit     = mask_i[idx_i[rrta_pkg::SlotW-1:0]];
    res_o.last    = (step_i == (n_i - rrta_pkg::CntW'(1)));
    res_o.ge      = (idx_i >= n_i);
    res_o.reduced = idx_i - n_i;
    res_o.stepped = (inc == n_i) ? '0 : inc;
  end

endmodule

`default_nettype wire

FILE: src/round_robin_turn_arbiter_top.sv
`default_nettype none

// Round-robin turn arbiter over eight requester slots with a connected mask.
// Each command transfer (connect, disconnect, advance, tick, start, end)
// yields exactly one result transfer that reports the state after the
// command: status, turn holder, one-hot grant, whether slot_id holds the
// turn, connected count, and the wrapping round and move counters. The
// slot_count register (reset value 2; 0 acts as 1, above 8 acts as 8) sets
// the rotation length and may be written only while the block is idle.
// The block works on one command at a time. Commands that need no search
// pass from decode straight to the done state. Advance, a tick while
// active with slots connected, and a disconnect of the turn holder search
// for the next connected slot with a single shared step unit: first the
// start index (holder plus one) is reduced modulo the rotation length by
// repeated subtraction, one subtraction per cycle, then the slots are
// tested one per cycle, at most the rotation length of them. The next
// command can be taken in the same cycle that the result turns valid. A
// finished result sits in the output register, and the next command is
// taken while it waits to be transferred out.
module round_robin_turn_arbiter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rrta_pkg::CntW-1:0]     cfg_slot_count_i,
  // Command channel.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [2:0]                    command_i,
  input  wire logic [rrta_pkg::SlotW-1:0]    slot_id_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [rrta_pkg::SlotW-1:0]         turn_holder_o,
  output logic [rrta_pkg::MaxSlots-1:0]      grant_onehot_o,
  output logic                               asked_has_turn_o,
  output logic [rrta_pkg::CntW-1:0]          connected_count_o,
  output logic [31:0]                        rounds_done_o,
  output logic [31:0]                        moves_done_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StReduce,
    StScan,
    StDone
  } state_e;

  state_e                          state_q;
  logic [2:0]                      cmd_q;
  logic [rrta_pkg::SlotW-1:0]      slot_q;
  logic [rrta_pkg::CntW-1:0]       idx_q;
  logic [rrta_pkg::CntW-1:0]       step_q;
  logic [1:0]                      status_q;
  logic [rrta_pkg::MaxSlots-1:0]   mask_q;
  logic [rrta_pkg::SlotW-1:0]      holder_q;
  logic [rrta_pkg::MaxSlots-1:0]   grant_q;
  logic [rrta_pkg::CntW-1:0]       live_q;
  logic [31:0]                     round_q;
  logic [31:0]                     move_q;
  logic                            active_q;
  logic [rrta_pkg::CntW-1:0]       slot_count_q;
  logic                            out_valid_q;

  logic [rrta_pkg::CntW-1:0]       eff_n;
  logic                            in_range;
  logic                            slot_conn;
  logic                            out_free;
  rrta_pkg::scan_res_t             scan;

  // The effective rotation length is the register clamped to 1..MaxSlots.
  always_comb begin
    if (slot_count_q == '0) begin
      eff_n = rrta_pkg::CntW'(1);
    end else if (slot_count_q > rrta_pkg::CntW'(rrta_pkg::MaxSlots)) begin
      eff_n = rrta_pkg::CntW'(rrta_pkg::MaxSlots);
    end else begin
      eff_n = slot_count_q;
    end
  end

  assign in_range  = ({1'b0, slot_q} < eff_n);
  assign slot_conn = mask_q[slot_q];
  assign out_free  = !out_valid_q || out_ready_i;

  // The shared step unit serves both the modulo reduction and the scan.
  rrta_scan_unit u_scan (
    .idx_i  (idx_q),
    .step_i (step_q),
    .n_i    (eff_n),
    .mask_i (mask_q),
    .res_o  (scan)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= StIdle;
      cmd_q             <= '0;
      slot_q            <= '0;
      idx_q             <= '0;
      step_q            <= '0;
      status_q          <= rrta_pkg::StOk;
      mask_q            <= '0;
      holder_q          <= '0;
      grant_q           <= '0;
      live_q            <= '0;
      round_q           <= '0;
      move_q            <= '0;
      active_q          <= 1'b0;
      slot_count_q      <= rrta_pkg::CntW'(2);
      out_valid_q       <= 1'b0;
      status_o          <= rrta_pkg::StOk;
      turn_holder_o     <= '0;
      grant_onehot_o    <= '0;
      asked_has_turn_o  <= 1'b0;
      connected_count_o <= '0;
      rounds_done_o     <= '0;
      moves_done_o      <= '0;
    end else begin
      if (cfg_valid_i) begin
        slot_count_q <= cfg_slot_count_i;
      end

      // In the done state the hand-over below decides the valid flag.
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cmd_q   <= command_i;
            slot_q  <= slot_id_i;
            state_q <= StDecode;
          end
        end

        StDecode: begin
          idx_q  <= {1'b0, holder_q} + rrta_pkg::CntW'(1);
          step_q <= '0;
          case (cmd_q)
            rrta_pkg::CmdConnect: begin
              state_q <= StDone;
              if (!in_range) begin
                status_q <= rrta_pkg::StRange;
              end else begin
                status_q <= rrta_pkg::StOk;
                if (!slot_conn) begin
                  mask_q[slot_q] <= 1'b1;
                  live_q         <= live_q + rrta_pkg::CntW'(1);
                end
              end
            end
            rrta_pkg::CmdDisconnect: begin
              if (!in_range) begin
                status_q <= rrta_pkg::StRange;
                state_q  <= StDone;
              end else begin
                status_q <= rrta_pkg::StOk;
                if (slot_conn) begin
                  mask_q[slot_q] <= 1'b0;
                  live_q         <= live_q - rrta_pkg::CntW'(1);
                  state_q        <= (holder_q == slot_q) ? StReduce : StDone;
                end else begin
                  state_q <= StDone;
                end
              end
            end
            rrta_pkg::CmdAdvance: begin
              status_q <= rrta_pkg::StOk;
              state_q  <= StReduce;
            end
            rrta_pkg::CmdTick: begin
              if (active_q && (live_q == '0)) begin
                status_q <= rrta_pkg::StNone;
              end else begin
                status_q <= rrta_pkg::StOk;
              end
              state_q <= (active_q && (live_q != '0)) ? StReduce : StDone;
            end
            rrta_pkg::CmdStart: begin
              status_q <= rrta_pkg::StOk;
              state_q  <= StDone;
              active_q <= 1'b1;
            end
            rrta_pkg::CmdEnd: begin
              status_q <= rrta_pkg::StOk;
              state_q  <= StDone;
              active_q <= 1'b0;
            end
            default: begin
              status_q <= rrta_pkg::StOk;
              state_q  <= StDone;
            end
          endcase
        end

        // Bring the start index below the rotation length.
        StReduce: begin
          if (scan.ge) begin
            idx_q <= scan.reduced;
          end else begin
            state_q <= StScan;
          end
        end

        // Test one slot per cycle, starting one past the holder.
        StScan: begin
          if (scan.hit) begin
            holder_q <= idx_q[rrta_pkg::SlotW-1:0];
            grant_q  <= rrta_pkg::MaxSlots'(1) << idx_q[rrta_pkg::SlotW-1:0];
            if (cmd_q != rrta_pkg::CmdDisconnect) begin
              move_q <= move_q + 32'd1;
            end
            if (cmd_q == rrta_pkg::CmdTick && idx_q == '0) begin
              round_q <= round_q + 32'd1;
            end
            state_q <= StDone;
          end else if (scan.last) begin
            if (cmd_q != rrta_pkg::CmdDisconnect) begin
              status_q <= rrta_pkg::StNone;
            end
            state_q <= StDone;
          end else begin
            idx_q  <= scan.stepped;
            step_q <= step_q + rrta_pkg::CntW'(1);
          end
        end

        StDone: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            status_o          <= status_q;
            turn_holder_o     <= holder_q;
            grant_onehot_o    <= grant_q;
            asked_has_turn_o  <= in_range && (holder_q == slot_q) && slot_conn;
            connected_count_o <= live_q;
            rounds_done_o     <= round_q;
            moves_done_o      <= move_q;
            state_q           <= StIdle;
          end
        end

        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // The connected count always tracks the population of the mask.
  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q == rrta_pkg::CntW'($countones(mask_q)))
    else $error("connected count differs from the connected mask");

  // The grant is empty or names exactly the holder.
  a_grant_is_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(grant_q) && ((grant_q == '0) || grant_q[holder_q]))
    else $error("grant does not match the turn holder");

  // The scan never tests more slots than the rotation holds.
  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> ((step_q < eff_n) && (idx_q < eff_n)))
    else $error("slot search ran past the rotation length");

  // A result becomes valid only when a finished command is handed over.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result valid raised outside of command completion");

endmodule

`default_nettype wire
